FILE: rtl/qrr_pkg.sv
// ----------------------------------------------------------------------------
// qrr_pkg
// shared widths and types for the quadratic real-root solver
// ----------------------------------------------------------------------------
package qrr_pkg;

  localparam int CoefWidth = 16;
  localparam int FracBits  = 16;
  localparam int OutWidth  = 33;
  // discriminant: b*b - 4ac needs 2*CoefWidth+2 bits signed
  localparam int DeltaWidth = 2 * CoefWidth + 2;
  // square-root radicand and root widths
  localparam int RadWidth  = DeltaWidth + 2 * FracBits;
  localparam int RootWidth = RadWidth / 2;
  // numerator (-b)*2^F +- s
  localparam int NumWidth  = ((CoefWidth + 1 + FracBits) > RootWidth ?
                              (CoefWidth + 1 + FracBits) : RootWidth) + 2;
  localparam int DenWidth  = CoefWidth + 1;
  localparam int QuoWidth  = NumWidth;

  typedef logic signed [OutWidth-1:0] out_t;

endpackage

FILE: rtl/qrr_if.sv
// ----------------------------------------------------------------------------
// qrr_in_if / qrr_out_if
// request and result channels of the quadratic real-root solver
// ----------------------------------------------------------------------------
interface qrr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qrr_pkg::CoefWidth-1:0] coef_a;
  logic signed [qrr_pkg::CoefWidth-1:0] coef_b;
  logic signed [qrr_pkg::CoefWidth-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrr_out_if;
  logic                 valid;
  logic                 ready;
  logic                 roots_valid;
  qrr_pkg::out_t        root_plus;
  qrr_pkg::out_t        root_minus;
  modport source (output valid, roots_valid, root_plus, root_minus, input ready);
  modport sink   (input valid, roots_valid, root_plus, root_minus, output ready);
endinterface

FILE: rtl/qrr_sqrt.sv
// ----------------------------------------------------------------------------
// qrr_sqrt
// pipelined restoring square root, one result bit per stage
// ----------------------------------------------------------------------------
module qrr_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [qrr_pkg::RadWidth-1:0]    rad,
  input  logic signed [qrr_pkg::CoefWidth-1:0] a_in,
  input  logic signed [qrr_pkg::CoefWidth-1:0] b_in,
  input  logic                            ok_in,
  output logic                            out_vld,
  output logic [qrr_pkg::RootWidth-1:0]   root,
  output logic signed [qrr_pkg::CoefWidth-1:0] a_out,
  output logic signed [qrr_pkg::CoefWidth-1:0] b_out,
  output logic                            ok_out
);
  import qrr_pkg::*;
  localparam int N = RootWidth;

  logic [RadWidth-1:0]  rem_r  [N+1];
  logic [RadWidth-1:0]  rad_r  [N+1];
  logic [N-1:0]         q_r    [N+1];
  logic                 vld_r  [N+1];
  logic signed [CoefWidth-1:0] a_r [N+1];
  logic signed [CoefWidth-1:0] b_r [N+1];
  logic                 ok_r   [N+1];

  always_comb begin
    rem_r[0] = '0;
    rad_r[0] = rad;
    q_r[0]   = '0;
    vld_r[0] = in_vld;
    a_r[0]   = a_in;
    b_r[0]   = b_in;
    ok_r[0]  = ok_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RadWidth-1:0] rem_sh, trial;
    logic [RadWidth-1:0] rem_nxt;
    logic [N-1:0]        q_nxt;
    always_comb begin
      rem_sh = {rem_r[i][RadWidth-3:0], rad_r[i][RadWidth-1 -: 2]};
      trial  = {{(RadWidth-N-2){1'b0}}, q_r[i], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt = rem_sh - trial;
        q_nxt   = {q_r[i][N-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[i][N-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        rem_r[i+1] <= rem_nxt;
        rad_r[i+1] <= {rad_r[i][RadWidth-3:0], 2'b00};
        q_r[i+1]   <= q_nxt;
        a_r[i+1]   <= a_r[i];
        b_r[i+1]   <= b_r[i];
        ok_r[i+1]  <= ok_r[i];
      end
    end
  end

  assign out_vld = vld_r[N];
  assign root    = q_r[N];
  assign a_out   = a_r[N];
  assign b_out   = b_r[N];
  assign ok_out  = ok_r[N];
endmodule

FILE: rtl/qrr_div.sv
// ----------------------------------------------------------------------------
// qrr_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [qrr_pkg::NumWidth-1:0]  num_p,
  input  logic [qrr_pkg::NumWidth-1:0]  num_m,
  input  logic                          neg_p,
  input  logic                          neg_m,
  input  logic [qrr_pkg::DenWidth-1:0]  den,
  input  logic                          ok_in,
  output logic                          out_vld,
  output logic [qrr_pkg::QuoWidth-1:0]  quo_p,
  output logic [qrr_pkg::QuoWidth-1:0]  quo_m,
  output logic                          neg_p_out,
  output logic                          neg_m_out,
  output logic                          ok_out
);
  import qrr_pkg::*;
  localparam int N = NumWidth;
  localparam int RW = DenWidth + 1;

  logic [N-1:0]   np_r [N+1];
  logic [N-1:0]   nm_r [N+1];
  logic [RW-1:0]  rp_r [N+1];
  logic [RW-1:0]  rm_r [N+1];
  logic [DenWidth-1:0] d_r [N+1];
  logic           v_r  [N+1];
  logic           sp_r [N+1];
  logic           sm_r [N+1];
  logic           ok_r [N+1];

  always_comb begin
    np_r[0] = num_p;
    nm_r[0] = num_m;
    rp_r[0] = '0;
    rm_r[0] = '0;
    d_r[0]  = den;
    v_r[0]  = in_vld;
    sp_r[0] = neg_p;
    sm_r[0] = neg_m;
    ok_r[0] = ok_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] tp, tm, rp_nxt, rm_nxt;
    logic          bp, bm;
    always_comb begin
      tp = {rp_r[i][RW-2:0], np_r[i][N-1]};
      tm = {rm_r[i][RW-2:0], nm_r[i][N-1]};
      bp = (tp >= {1'b0, d_r[i]});
      bm = (tm >= {1'b0, d_r[i]});
      rp_nxt = bp ? tp - {1'b0, d_r[i]} : tp;
      rm_nxt = bm ? tm - {1'b0, d_r[i]} : tm;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        np_r[i+1] <= {np_r[i][N-2:0], bp};
        nm_r[i+1] <= {nm_r[i][N-2:0], bm};
        rp_r[i+1] <= rp_nxt;
        rm_r[i+1] <= rm_nxt;
        d_r[i+1]  <= d_r[i];
        sp_r[i+1] <= sp_r[i];
        sm_r[i+1] <= sm_r[i];
        ok_r[i+1] <= ok_r[i];
      end
    end
  end

  assign out_vld   = v_r[N];
  assign quo_p     = np_r[N];
  assign quo_m     = nm_r[N];
  assign neg_p_out = sp_r[N];
  assign neg_m_out = sm_r[N];
  assign ok_out    = ok_r[N];
endmodule

FILE: rtl/quadratic_real_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_real_root_solver
// real roots of a*x^2 + b*x + c in signed Q16.16
// ----------------------------------------------------------------------------
// One request per cycle is accepted when the pipeline is not stalled. The
// pipeline has one multiply stage, one discriminant stage, one square-root
// stage per root bit (RootWidth, 33), one numerator stage, one divider stage
// per numerator bit (NumWidth, 35) and the output register, which also
// applies the sign and saturation. The whole pipeline advances together and
// holds while the result register is full and not taken.
module quadratic_real_root_solver (
  input logic clk,
  input logic rst_n,
  qrr_in_if.sink    in_ch,
  qrr_out_if.source out_ch
);
  import qrr_pkg::*;

  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: products
  logic                        s1_vld_r;
  logic signed [CoefWidth-1:0] s1_a_r, s1_b_r;
  logic signed [2*CoefWidth-1:0] s1_bb_r, s1_ac_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_ch.valid;
    if (en) begin
      s1_a_r  <= in_ch.coef_a;
      s1_b_r  <= in_ch.coef_b;
      s1_bb_r <= (2*CoefWidth)'(in_ch.coef_b) * (2*CoefWidth)'(in_ch.coef_b);
      s1_ac_r <= (2*CoefWidth)'(in_ch.coef_a) * (2*CoefWidth)'(in_ch.coef_c);
    end
  end

  // stage 2: discriminant
  logic                         s2_vld_r, s2_ok_r;
  logic signed [CoefWidth-1:0]  s2_a_r, s2_b_r;
  logic [RadWidth-1:0]          s2_rad_r;
  logic signed [DeltaWidth-1:0] delta;
  assign delta = DeltaWidth'(s1_bb_r) - (DeltaWidth'(s1_ac_r) <<< 2);
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
    if (en) begin
      s2_a_r   <= s1_a_r;
      s2_b_r   <= s1_b_r;
      s2_ok_r  <= (s1_a_r != '0) && !delta[DeltaWidth-1];
      s2_rad_r <= RadWidth'({delta[DeltaWidth-2:0], 1'b0}) << (2 * FracBits - 1);
    end
  end

  logic                        sq_vld, sq_ok;
  logic [RootWidth-1:0]        sq_root;
  logic signed [CoefWidth-1:0] sq_a, sq_b;
  qrr_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_vld(s2_vld_r), .rad(s2_rad_r), .a_in(s2_a_r), .b_in(s2_b_r), .ok_in(s2_ok_r),
    .out_vld(sq_vld), .root(sq_root), .a_out(sq_a), .b_out(sq_b), .ok_out(sq_ok)
  );

  // numerator stage: magnitudes and signs of (-b*2^F +- s) and 2a
  logic signed [NumWidth-1:0] nb, np, nm;
  logic signed [DenWidth-1:0] den_s;
  logic                       n_vld_r, n_ok_r, n_sp_r, n_sm_r;
  logic [NumWidth-1:0]        n_np_r, n_nm_r;
  logic [DenWidth-1:0]        n_den_r;
  always_comb begin
    nb    = -(NumWidth'(sq_b) <<< FracBits);
    np    = nb + NumWidth'(sq_root);
    nm    = nb - NumWidth'(sq_root);
    den_s = DenWidth'(sq_a) <<< 1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) n_vld_r <= 1'b0;
    else if (en) n_vld_r <= sq_vld;
    if (en) begin
      n_ok_r  <= sq_ok;
      n_np_r  <= np[NumWidth-1] ? NumWidth'(-np) : NumWidth'(np);
      n_nm_r  <= nm[NumWidth-1] ? NumWidth'(-nm) : NumWidth'(nm);
      n_den_r <= den_s[DenWidth-1] ? DenWidth'(-den_s) : DenWidth'(den_s);
      n_sp_r  <= np[NumWidth-1] ^ den_s[DenWidth-1];
      n_sm_r  <= nm[NumWidth-1] ^ den_s[DenWidth-1];
    end
  end

  logic                d_vld, d_ok, d_sp, d_sm;
  logic [QuoWidth-1:0] d_qp, d_qm;
  qrr_div u_div (
    .clk, .rst_n, .en,
    .in_vld(n_vld_r), .num_p(n_np_r), .num_m(n_nm_r), .neg_p(n_sp_r), .neg_m(n_sm_r),
    .den(n_den_r), .ok_in(n_ok_r),
    .out_vld(d_vld), .quo_p(d_qp), .quo_m(d_qm), .neg_p_out(d_sp), .neg_m_out(d_sm),
    .ok_out(d_ok)
  );

  // sign, saturate, output register
  function automatic out_t sat_fn(input logic [QuoWidth-1:0] q, input logic neg);
    logic signed [QuoWidth+1:0] v;
    v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (v > (QuoWidth+2)'(signed'(OutWidth'({1'b0, {(OutWidth-1){1'b1}}}))))
      return {1'b0, {(OutWidth-1){1'b1}}};
    else if (v < -((QuoWidth+2)'(1) <<< (OutWidth-1)))
      return {1'b1, {(OutWidth-1){1'b0}}};
    else
      return v[OutWidth-1:0];
  endfunction

  logic out_rv_r;
  out_t out_p_r, out_m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= d_vld;
    if (en) begin
      out_rv_r <= d_ok;
      out_p_r  <= d_ok ? sat_fn(d_qp, d_sp) : '0;
      out_m_r  <= d_ok ? sat_fn(d_qm, d_sm) : '0;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.roots_valid = out_rv_r;
  assign out_ch.root_plus   = out_p_r;
  assign out_ch.root_minus  = out_m_r;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_p_r) && $stable(out_m_r))
    else $error("result changed under stall");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_rv_r |-> out_p_r == '0 && out_m_r == '0)
    else $error("no-root result not zero");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty output");
`endif
endmodule
